[sv/dmrw_pkg.sv]
package dmrw_pkg;

  // command queue depth between the front and back parts
  localparam int FIFO_DEPTH = 2;

  // action codes on the input channel
  localparam logic [2:0] ACT_TICK  = 3'd0;
  localparam logic [2:0] ACT_SET_A = 3'd1;
  localparam logic [2:0] ACT_SET_B = 3'd2;
  localparam logic [2:0] ACT_STOP  = 3'd3;
  localparam logic [2:0] ACT_ESTOP = 3'd4;
  localparam logic [2:0] ACT_SEEN  = 3'd5;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_ACCEL_STEP   = 3'd0;
  localparam logic [2:0] REG_RAMP_PERIOD  = 3'd1;
  localparam logic [2:0] REG_MAX_SPEED    = 3'd2;
  localparam logic [2:0] REG_TRIM_A       = 3'd3;
  localparam logic [2:0] REG_TRIM_B       = 3'd4;
  localparam logic [2:0] REG_WD_LIMIT     = 3'd5;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_SET_A,
    OP_SET_B,
    OP_STOP,
    OP_ESTOP,
    OP_SEEN,
    OP_NONE
  } op_t;

  typedef logic signed [8:0] speed_t;

  typedef struct packed {
    op_t    op;
    speed_t speed;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  typedef struct packed {
    logic        [7:0]  accel_step;
    logic        [15:0] ramp_period_ms;
    logic        [7:0]  max_speed;
    logic signed [7:0]  trim_a;
    logic signed [7:0]  trim_b;
    logic        [15:0] watchdog_limit_ms;
  } cfg_t;

  typedef struct packed {
    logic signed [1:0] dir;
    logic        [7:0] pwm;
  } drive_t;

endpackage

[sv/dmrw_front.sv]
module dmrw_front
  import dmrw_pkg::*;
(
  input  logic               in_valid,
  input  logic [2:0]         in_action,
  input  logic signed [15:0] in_speed_value,
  output logic               in_stall,
  input  fifo_stat_t         fifo_stat,
  output logic               push,
  output cmd_t               cmd
);

  localparam logic signed [15:0] SPD_HI = 16'sd255;
  localparam logic signed [15:0] SPD_LO = -16'sd255;

  assign in_stall = fifo_stat.full;
  assign push     = in_valid & ~fifo_stat.full;

  always_comb begin
    case (in_action)
      ACT_TICK:  cmd.op = OP_TICK;
      ACT_SET_A: cmd.op = OP_SET_A;
      ACT_SET_B: cmd.op = OP_SET_B;
      ACT_STOP:  cmd.op = OP_STOP;
      ACT_ESTOP: cmd.op = OP_ESTOP;
      ACT_SEEN:  cmd.op = OP_SEEN;
      default:   cmd.op = OP_NONE;
    endcase

    // saturate to the legal speed range
    if (in_speed_value > SPD_HI) begin
      cmd.speed = SPD_HI[8:0];
    end else if (in_speed_value < SPD_LO) begin
      cmd.speed = SPD_LO[8:0];
    end else begin
      cmd.speed = in_speed_value[8:0];
    end
  end

endmodule

[sv/dmrw_fifo.sv]
module dmrw_fifo
  import dmrw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  cmd_t       din,
  input  logic       pop,
  output cmd_t       dout,
  output fifo_stat_t stat
);

  localparam int IDX_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FIFO_DEPTH);

  cmd_t             mem_r [FIFO_DEPTH];
  logic [IDX_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [IDX_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == FULL_CNT);
  assign dout       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

[sv/dmrw_scale.sv]
// pwm = min(255, floor(mag * max_speed * (100 + trim) / 25500)), trim clamped to [-100, 100], registered
module dmrw_scale (
  input  logic              clk,
  input  logic [7:0]        mag,
  input  logic [7:0]        max_speed,
  input  logic signed [7:0] trim,
  output logic [7:0]        pwm
);

  localparam int PWM_DIV_I   = 25500;
  localparam int RECIP_SHIFT = 24;
  localparam logic [23:0] PWM_DIV    = 24'(PWM_DIV_I);
  localparam logic [9:0]  RECIP_MUL  = 10'((1 << RECIP_SHIFT) / PWM_DIV_I);
  localparam logic [23:0] SAT_THRESH = 24'(255 * PWM_DIV_I);
  localparam logic signed [7:0] TRIM_HI = 8'sd100;
  localparam logic signed [7:0] TRIM_LO = -8'sd100;
  localparam logic signed [8:0] TRIM_BIAS = 9'sd100;

  logic signed [7:0] trim_c;
  logic signed [8:0] tf_wide;
  logic [15:0] p1_r;
  logic [7:0]  tf_r;
  logic [23:0] p2_r;
  logic [22:0] p2d_r;
  logic [8:0]  q0_r;
  logic        sat_r;
  logic [32:0] recip_prod;
  logic [23:0] q_prod;
  logic [23:0] rem;
  logic [8:0]  q1;
  logic [7:0]  pwm_r;

  always_comb begin
    if (trim > TRIM_HI) begin
      trim_c = TRIM_HI;
    end else if (trim < TRIM_LO) begin
      trim_c = TRIM_LO;
    end else begin
      trim_c = trim;
    end
    tf_wide = {trim_c[7], trim_c} + TRIM_BIAS;
  end

  // estimate is the true quotient or one less; one compare fixes it
  assign recip_prod = 33'(p2_r[22:0]) * 33'(RECIP_MUL);
  assign q_prod     = 24'(q0_r) * PWM_DIV;
  assign rem        = 24'(p2d_r) - q_prod;
  assign q1         = q0_r + 9'(rem >= PWM_DIV);

  always_ff @(posedge clk) begin
    p1_r  <= 16'(mag) * 16'(max_speed);
    tf_r  <= tf_wide[7:0];
    p2_r  <= 24'(p1_r) * 24'(tf_r);
    q0_r  <= recip_prod[RECIP_SHIFT +: 9];
    p2d_r <= p2_r[22:0];
    sat_r <= (p2_r >= SAT_THRESH);
    pwm_r <= sat_r ? 8'hFF : q1[7:0];
  end

  assign pwm = pwm_r;

endmodule

[sv/dmrw_back.sv]
module dmrw_back
  import dmrw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  fifo_stat_t        fifo_stat,
  input  cmd_t              fifo_dout,
  output logic              pop,
  input  logic              out_stall,
  output logic              out_valid,
  output logic signed [1:0] out_dir_a,
  output logic [7:0]        out_pwm_a,
  output logic signed [1:0] out_dir_b,
  output logic [7:0]        out_pwm_b,
  output logic              out_ramp_fired,
  output logic              out_watchdog_stopped
);

  localparam int SCALE_LAT = 4;
  localparam logic [1:0]  SCALE_LAST   = 2'(SCALE_LAT - 1);
  localparam logic [7:0]  STEP_JUMP    = 8'd255;
  localparam logic [15:0] RAMP_CNT_MAX = 16'hFFFF;
  localparam logic [16:0] CMD_CNT_MAX  = 17'h1FFFF;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_EXEC  = 4'b0010,
    ST_SCALE = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  function automatic speed_t slew(speed_t cur, speed_t tgt, logic [7:0] step);
    logic signed [9:0] diff;
    logic signed [9:0] ndiff;
    logic [8:0]        mag;
    logic [9:0]        moved;
    speed_t            res;
    diff  = {tgt[8], tgt} - {cur[8], cur};
    ndiff = -diff;
    mag   = diff[9] ? ndiff[8:0] : diff[8:0];
    if (step == STEP_JUMP || mag <= {1'b0, step}) begin
      res = tgt;
    end else begin
      if (diff[9]) begin
        moved = {cur[8], cur} - {2'b00, step};
      end else begin
        moved = {cur[8], cur} + {2'b00, step};
      end
      res = moved[8:0];
    end
    return res;
  endfunction

  function automatic logic signed [1:0] sign_of(speed_t s);
    logic signed [1:0] d;
    if (s > 9'sd0) begin
      d = 2'sd1;
    end else if (s < 9'sd0) begin
      d = -2'sd1;
    end else begin
      d = 2'sd0;
    end
    return d;
  endfunction

  state_t      state_r, state_nxt;
  cmd_t        cmd_r, cmd_nxt;
  speed_t      tgt_a_r, tgt_a_nxt, tgt_b_r, tgt_b_nxt;
  speed_t      cur_a_r, cur_a_nxt, cur_b_r, cur_b_nxt;
  logic [15:0] ramp_cnt_r, ramp_cnt_nxt;
  logic [16:0] cmd_cnt_r, cmd_cnt_nxt;
  drive_t      drv_a_r, drv_a_nxt, drv_b_r, drv_b_nxt;
  logic        fired_r, fired_nxt, wd_r, wd_nxt;
  logic [1:0]  lat_cnt_r, lat_cnt_nxt;

  logic              out_valid_r, out_valid_nxt;
  drive_t            out_a_r, out_a_nxt, out_b_r, out_b_nxt;
  logic              out_fired_r, out_fired_nxt, out_wd_r, out_wd_nxt;

  logic [15:0] ramp_inc;
  logic [16:0] cmd_inc;
  logic        fire, wd_trip, out_free;
  speed_t      neg_a, neg_b;
  logic [7:0]  pwm_a, pwm_b;
  drive_t      new_a, new_b;

  assign neg_a = -cur_a_r;
  assign neg_b = -cur_b_r;

  dmrw_scale u_scale_a (
    .clk       (clk),
    .mag       (cur_a_r[8] ? neg_a[7:0] : cur_a_r[7:0]),
    .max_speed (cfg.max_speed),
    .trim      (cfg.trim_a),
    .pwm       (pwm_a)
  );

  dmrw_scale u_scale_b (
    .clk       (clk),
    .mag       (cur_b_r[8] ? neg_b[7:0] : cur_b_r[7:0]),
    .max_speed (cfg.max_speed),
    .trim      (cfg.trim_b),
    .pwm       (pwm_b)
  );

  always_comb begin
    ramp_inc = (ramp_cnt_r == RAMP_CNT_MAX) ? ramp_cnt_r : ramp_cnt_r + 16'd1;
    cmd_inc  = (cmd_cnt_r == CMD_CNT_MAX) ? cmd_cnt_r : cmd_cnt_r + 17'd1;
    fire     = (ramp_inc >= cfg.ramp_period_ms);
    wd_trip  = (cfg.watchdog_limit_ms != '0) &&
               (cmd_inc > {1'b0, cfg.watchdog_limit_ms}) &&
               (tgt_a_r != '0 || tgt_b_r != '0);
    out_free = ~out_valid_r | ~out_stall;

    new_a.dir = sign_of(cur_a_r);
    new_a.pwm = (new_a.dir == 2'sd0) ? 8'd0 : pwm_a;
    new_b.dir = sign_of(cur_b_r);
    new_b.pwm = (new_b.dir == 2'sd0) ? 8'd0 : pwm_b;
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    tgt_a_nxt     = tgt_a_r;
    tgt_b_nxt     = tgt_b_r;
    cur_a_nxt     = cur_a_r;
    cur_b_nxt     = cur_b_r;
    ramp_cnt_nxt  = ramp_cnt_r;
    cmd_cnt_nxt   = cmd_cnt_r;
    drv_a_nxt     = drv_a_r;
    drv_b_nxt     = drv_b_r;
    fired_nxt     = fired_r;
    wd_nxt        = wd_r;
    lat_cnt_nxt   = lat_cnt_r;
    pop           = 1'b0;
    out_valid_nxt = out_valid_r & out_stall;
    out_a_nxt     = out_a_r;
    out_b_nxt     = out_b_r;
    out_fired_nxt = out_fired_r;
    out_wd_nxt    = out_wd_r;

    case (state_r)
      ST_IDLE: begin
        if (!fifo_stat.empty) begin
          pop       = 1'b1;
          cmd_nxt   = fifo_dout;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        fired_nxt   = 1'b0;
        wd_nxt      = 1'b0;
        lat_cnt_nxt = '0;
        state_nxt   = ST_DONE;
        case (cmd_r.op)
          OP_TICK: begin
            ramp_cnt_nxt = fire ? '0 : ramp_inc;
            cmd_cnt_nxt  = cmd_inc;
            if (fire) begin
              cur_a_nxt = slew(cur_a_r, tgt_a_r, cfg.accel_step);
              cur_b_nxt = slew(cur_b_r, tgt_b_r, cfg.accel_step);
              fired_nxt = 1'b1;
              state_nxt = ST_SCALE;
            end
            if (wd_trip) begin
              tgt_a_nxt = '0;
              tgt_b_nxt = '0;
              wd_nxt    = 1'b1;
            end
          end
          OP_SET_A: tgt_a_nxt = cmd_r.speed;
          OP_SET_B: tgt_b_nxt = cmd_r.speed;
          OP_STOP: begin
            tgt_a_nxt = '0;
            tgt_b_nxt = '0;
          end
          OP_ESTOP: begin
            tgt_a_nxt = '0;
            tgt_b_nxt = '0;
            cur_a_nxt = '0;
            cur_b_nxt = '0;
            drv_a_nxt = '0;
            drv_b_nxt = '0;
          end
          OP_SEEN: cmd_cnt_nxt = '0;
          default: ;
        endcase
      end
      ST_SCALE: begin
        lat_cnt_nxt = lat_cnt_r + 2'd1;
        if (lat_cnt_r == SCALE_LAST) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          if (fired_r) begin
            drv_a_nxt = new_a;
            drv_b_nxt = new_b;
          end
          out_valid_nxt = 1'b1;
          out_a_nxt     = fired_r ? new_a : drv_a_r;
          out_b_nxt     = fired_r ? new_b : drv_b_r;
          out_fired_nxt = fired_r;
          out_wd_nxt    = wd_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tgt_a_r     <= '0;
      tgt_b_r     <= '0;
      cur_a_r     <= '0;
      cur_b_r     <= '0;
      ramp_cnt_r  <= '0;
      cmd_cnt_r   <= '0;
      drv_a_r     <= '0;
      drv_b_r     <= '0;
      fired_r     <= 1'b0;
      wd_r        <= 1'b0;
      lat_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tgt_a_r     <= tgt_a_nxt;
      tgt_b_r     <= tgt_b_nxt;
      cur_a_r     <= cur_a_nxt;
      cur_b_r     <= cur_b_nxt;
      ramp_cnt_r  <= ramp_cnt_nxt;
      cmd_cnt_r   <= cmd_cnt_nxt;
      drv_a_r     <= drv_a_nxt;
      drv_b_r     <= drv_b_nxt;
      fired_r     <= fired_nxt;
      wd_r        <= wd_nxt;
      lat_cnt_r   <= lat_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    out_a_r     <= out_a_nxt;
    out_b_r     <= out_b_nxt;
    out_fired_r <= out_fired_nxt;
    out_wd_r    <= out_wd_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_dir_a            = out_a_r.dir;
  assign out_pwm_a            = out_a_r.pwm;
  assign out_dir_b            = out_b_r.dir;
  assign out_pwm_b            = out_b_r.pwm;
  assign out_ramp_fired       = out_fired_r;
  assign out_watchdog_stopped = out_wd_r;

endmodule

[sv/dual_motor_ramp_watchdog_top.sv]
// Channel   | Direction | Handshake                  | Payload
// ----------+-----------+----------------------------+-----------------------------------
// in_       | input     | in_valid / in_stall        | action, speed_value
// out_      | output    | out_valid / out_stall      | dir_a, pwm_a, dir_b, pwm_b, flags
// APB       | input     | psel, penable, pwrite      | paddr, pwdata -> prdata, pready=1
//
// Sequencing: one transaction at a time in the back end. A tick that fires the ramp
//   passes queue pop, execute, the scaling pipeline and result load; every other
//   transaction passes queue pop, execute and result load, skipping the scaling pipeline.
// Reset: synchronous, active low; clears the queue, motor state and the
//   configuration registers to their defaults.
// Stalls: a 2-entry queue lets input keep landing while out_stall holds a result, until it fills.
module dual_motor_ramp_watchdog_top
  import dmrw_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,

  // command transactions
  input  logic               in_valid,
  input  logic [2:0]         in_action,
  input  logic signed [15:0] in_speed_value,
  output logic               in_stall,

  // drive status transactions
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [1:0]  out_dir_a,
  output logic [7:0]         out_pwm_a,
  output logic signed [1:0]  out_dir_b,
  output logic [7:0]         out_pwm_b,
  output logic               out_ramp_fired,
  output logic               out_watchdog_stopped,

  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // register defaults
  localparam logic [7:0]  ACCEL_STEP_RST  = 8'd255;
  localparam logic [15:0] RAMP_PERIOD_RST = 16'd20;
  localparam logic [7:0]  MAX_SPEED_RST   = 8'd200;

  cfg_t       cfg_r;
  logic       reg_we;
  logic [2:0] reg_idx;

  fifo_stat_t fifo_stat;
  cmd_t       push_cmd, pop_cmd;
  logic       push, pop;

  // ---------------------------------------------------------------------
  // Register file: written on the access phase, read back combinationally
  // ---------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_we  = psel & penable & pwrite & pready;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.accel_step        <= ACCEL_STEP_RST;
      cfg_r.ramp_period_ms    <= RAMP_PERIOD_RST;
      cfg_r.max_speed         <= MAX_SPEED_RST;
      cfg_r.trim_a            <= '0;
      cfg_r.trim_b            <= '0;
      cfg_r.watchdog_limit_ms <= '0;
    end else if (reg_we) begin
      case (reg_idx)
        REG_ACCEL_STEP:  cfg_r.accel_step        <= pwdata[7:0];
        REG_RAMP_PERIOD: cfg_r.ramp_period_ms    <= pwdata[15:0];
        REG_MAX_SPEED:   cfg_r.max_speed         <= pwdata[7:0];
        REG_TRIM_A:      cfg_r.trim_a            <= pwdata[7:0];
        REG_TRIM_B:      cfg_r.trim_b            <= pwdata[7:0];
        REG_WD_LIMIT:    cfg_r.watchdog_limit_ms <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ACCEL_STEP:  prdata = 32'(cfg_r.accel_step);
      REG_RAMP_PERIOD: prdata = 32'(cfg_r.ramp_period_ms);
      REG_MAX_SPEED:   prdata = 32'(cfg_r.max_speed);
      REG_TRIM_A:      prdata = 32'(unsigned'(cfg_r.trim_a));
      REG_TRIM_B:      prdata = 32'(unsigned'(cfg_r.trim_b));
      REG_WD_LIMIT:    prdata = 32'(cfg_r.watchdog_limit_ms);
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Front end: decode action, saturate speed, push into the queue
  // ---------------------------------------------------------------------
  dmrw_front u_front (
    .in_valid       (in_valid),
    .in_action      (in_action),
    .in_speed_value (in_speed_value),
    .in_stall       (in_stall),
    .fifo_stat      (fifo_stat),
    .push           (push),
    .cmd            (push_cmd)
  );

  dmrw_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (push_cmd),
    .pop   (pop),
    .dout  (pop_cmd),
    .stat  (fifo_stat)
  );

  // ---------------------------------------------------------------------
  // Back end: ramp timers, slew, watchdog, drive scaling, result register
  // ---------------------------------------------------------------------
  dmrw_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg_r),
    .fifo_stat            (fifo_stat),
    .fifo_dout            (pop_cmd),
    .pop                  (pop),
    .out_stall            (out_stall),
    .out_valid            (out_valid),
    .out_dir_a            (out_dir_a),
    .out_pwm_a            (out_pwm_a),
    .out_dir_b            (out_dir_b),
    .out_pwm_b            (out_pwm_b),
    .out_ramp_fired       (out_ramp_fired),
    .out_watchdog_stopped (out_watchdog_stopped)
  );

endmodule

[sv/dmrw_checker.sv]
module dmrw_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic signed [1:0] out_dir_a,
  input logic [7:0]        out_pwm_a,
  input logic signed [1:0] out_dir_b,
  input logic [7:0]        out_pwm_b,
  input logic              out_ramp_fired,
  input logic              out_watchdog_stopped
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_dir_a) && $stable(out_pwm_a) &&
      $stable(out_dir_b) && $stable(out_pwm_b) && $stable(out_ramp_fired) &&
      $stable(out_watchdog_stopped))
    else $error("result changed while stalled");

  // a coasting motor shows no drive
  a_coast_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_dir_a != 2'sd0 || out_pwm_a == 8'd0) &&
                  (out_dir_b != 2'sd0 || out_pwm_b == 8'd0))
    else $error("pwm nonzero while coasting");

  // direction is never the unused code
  a_dir_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_dir_a != -2'sd2 && out_dir_b != -2'sd2)
    else $error("illegal direction code");

  // reset drops the result
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind dual_motor_ramp_watchdog_top dmrw_checker u_dmrw_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_dir_a            (out_dir_a),
  .out_pwm_a            (out_pwm_a),
  .out_dir_b            (out_dir_b),
  .out_pwm_b            (out_pwm_b),
  .out_ramp_fired       (out_ramp_fired),
  .out_watchdog_stopped (out_watchdog_stopped)
);
